// ===== src/cbts_pkg.sv =====
// shared types and constants for the cubic bezier timing solver
// no dependencies

package cbts_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_DIVSET,
		ST_DIV,
		ST_UPD,
		ST_FINAL,
		ST_OUT
	} state_t;

	// multiplier micro-op sequence: value ops then slope ops
	localparam logic [3:0] OP_UU    = 4'd0;
	localparam logic [3:0] OP_US    = 4'd1;
	localparam logic [3:0] OP_SS    = 4'd2;
	localparam logic [3:0] OP_UUS   = 4'd3;
	localparam logic [3:0] OP_A     = 4'd4;
	localparam logic [3:0] OP_USS   = 4'd5;
	localparam logic [3:0] OP_B     = 4'd6;
	localparam logic [3:0] OP_C     = 4'd7;
	localparam logic [3:0] OP_DA    = 4'd8;
	localparam logic [3:0] OP_DB    = 4'd9;
	localparam logic [3:0] OP_DC    = 4'd10;

	localparam logic [2:0] REG_CTRL1_X = 3'd0;
	localparam logic [2:0] REG_CTRL1_Y = 3'd1;
	localparam logic [2:0] REG_CTRL2_X = 3'd2;
	localparam logic [2:0] REG_CTRL2_Y = 3'd3;

	localparam int NEWTON_TOL = 7;

endpackage

// ===== src/cubic_bezier_timing_solver.sv =====
// cubic bezier timing curve solver, top level
// depends on cbts_pkg
//
// Accepts a time fraction on start when busy is low and answers Y(s) with a one-cycle done
// strobe; the receiver cannot stall. Zero and one-or-above time skip the solver and go
// straight to the output state. Otherwise each Newton step runs 8 multiplier ops and a
// check for X(s), then 3 multiplier ops for the slope, a divider setup, the bit-serial
// divider and an update; a step that meets the tolerance stops after its check, and a zero
// slope stops at the divider setup. Up to NEWTON_STEPS steps are run, then a clamp, 8
// multiplier ops for Y and an output state, and done follows in the next cycle.
// One shared multiplier and one restoring divider under a small sequencer do all work.

module cubic_bezier_timing_solver #(
	parameter int NEWTON_STEPS = 8,
	parameter int FRAC_BITS    = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [FRAC_BITS:0]      time_frac,
	output logic                    done,
	output logic signed [FRAC_BITS+2:0] eased_value,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [FRAC_BITS+1:0]    cfg_data
);
	import cbts_pkg::*;

	localparam int XW = FRAC_BITS + 1;
	localparam int YW = FRAC_BITS + 2;
	localparam int OW = FRAC_BITS + 3;
	localparam int SW = FRAC_BITS + 4;
	localparam int MW = FRAC_BITS + 9;
	localparam int DW = FRAC_BITS + 14;
	localparam int NW = DW + FRAC_BITS;
	localparam int IW = $clog2(NEWTON_STEPS + 1);
	localparam int CW = $clog2(NW + 1);

	localparam logic signed [SW-1:0] S_ONE = SW'(1) <<< FRAC_BITS;
	localparam logic signed [SW-1:0] S_LIM = SW'(4) <<< FRAC_BITS;
	localparam logic signed [DW-1:0] D_ONE = DW'(1) <<< FRAC_BITS;
	localparam logic signed [DW-1:0] O_MAX = DW'((64'(1) << (OW - 1)) - 1);
	localparam logic signed [DW-1:0] O_MIN = -(DW'(1) <<< (OW - 1));

	state_t state_q, state_d;

	logic [XW-1:0] c1x_q, c2x_q, t_q;
	logic [YW-1:0] c1y_q, c2y_q;
	logic signed [SW-1:0] s_q;
	logic signed [MW-1:0] uu_q, us_q, ss_q, tmp_q;
	logic signed [DW-1:0] acc_q, e_q;
	logic [3:0] op_q;
	logic [IW-1:0] iter_q;
	logic mode_y_q, neg_q, done_q;
	logic [DW-1:0] den_q, rem_q;
	logic [NW-1:0] num_q;
	logic [CW-1:0] cnt_q;

	// config writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1x_q <= '0;
			c1y_q <= '0;
			c2x_q <= XW'(1) << FRAC_BITS;
			c2y_q <= YW'(1) << FRAC_BITS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CTRL1_X: c1x_q <= cfg_data[XW-1:0];
				REG_CTRL1_Y: c1y_q <= cfg_data;
				REG_CTRL2_X: c2x_q <= cfg_data[XW-1:0];
				REG_CTRL2_Y: c2y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand selection for the shared multiplier
	logic signed [MW-1:0] p1, p2, s_m, u_m, opa, opb;
	assign p1  = mode_y_q ? MW'($signed(c1y_q)) : MW'($signed({1'b0, c1x_q}));
	assign p2  = mode_y_q ? MW'($signed(c2y_q)) : MW'($signed({1'b0, c2x_q}));
	assign s_m = MW'(s_q);
	assign u_m = MW'(S_ONE) - s_m;

	always_comb begin
		opa = uu_q;
		opb = s_m;
		unique case (op_q)
			OP_UU:  begin opa = u_m;   opb = u_m;                end
			OP_US:  begin opa = u_m;   opb = s_m;                end
			OP_SS:  begin opa = s_m;   opb = s_m;                end
			OP_UUS: begin opa = uu_q;  opb = s_m;                end
			OP_A:   begin opa = tmp_q; opb = p1;                 end
			OP_USS: begin opa = us_q;  opb = s_m;                end
			OP_B:   begin opa = tmp_q; opb = p2;                 end
			OP_C:   begin opa = ss_q;  opb = s_m;                end
			OP_DA:  begin opa = uu_q;  opb = p1;                 end
			OP_DB:  begin opa = us_q;  opb = p2 - p1;            end
			OP_DC:  begin opa = ss_q;  opb = MW'(S_ONE) - p2;    end
			default: begin opa = uu_q; opb = s_m;                end
		endcase
	end

	// rounded fixed-point product, ties away from zero
	logic [MW-1:0] mag_a, mag_b;
	logic [2*MW-1:0] mag_p;
	logic [DW-1:0] mag_r;
	logic signed [DW-1:0] prod, term;
	assign mag_a = opa[MW-1] ? MW'(-opa) : MW'(opa);
	assign mag_b = opb[MW-1] ? MW'(-opb) : MW'(opb);
	assign mag_p = mag_a * mag_b + ((2*MW)'(1) << (FRAC_BITS - 1));
	assign mag_r = mag_p[FRAC_BITS +: DW];
	assign prod  = (opa[MW-1] ^ opb[MW-1]) ? -$signed(mag_r) : $signed(mag_r);

	always_comb begin
		unique case (op_q)
			OP_A, OP_B, OP_DA, OP_DC: term = prod + (prod <<< 1);
			OP_DB:                    term = (prod <<< 2) + (prod <<< 1);
			OP_C:                     term = prod;
			default:                  term = '0;
		endcase
	end

	logic signed [DW-1:0] e_now;
	logic e_small;
	assign e_now   = acc_q - DW'($signed({1'b0, t_q}));
	assign e_small = (e_now > -DW'(NEWTON_TOL)) && (e_now < DW'(NEWTON_TOL));

	// divider trial subtract
	logic [DW:0] trial;
	assign trial = {rem_q, num_q[NW-1]} - {1'b0, den_q};

	// s update with saturation
	logic signed [NW+1:0] q_s, s_new;
	assign q_s   = neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
	assign s_new = (NW+2)'(s_q) - q_s;

	logic t_zero, t_big;
	assign t_zero = (time_frac == '0);
	assign t_big  = time_frac[FRAC_BITS];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) begin
				state_d = (t_zero || t_big) ? ST_OUT : ST_MUL;
			end
			ST_MUL: begin
				if (op_q == OP_C && mode_y_q) state_d = ST_OUT;
				else if (op_q == OP_C) state_d = ST_CHECK;
				else if (op_q == OP_DC) state_d = ST_DIVSET;
			end
			ST_CHECK:  state_d = e_small ? ST_FINAL : ST_MUL;
			ST_DIVSET: state_d = (acc_q == '0) ? ST_FINAL : ST_DIV;
			ST_DIV:    if (cnt_q == CW'(NW - 1)) state_d = ST_UPD;
			ST_UPD:    state_d = (iter_q == IW'(NEWTON_STEPS - 1)) ? ST_FINAL : ST_MUL;
			ST_FINAL:  state_d = ST_MUL;
			ST_OUT:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
		done = done_q;
		if (acc_q > O_MAX) eased_value = OW'(O_MAX);
		else if (acc_q < O_MIN) eased_value = OW'(O_MIN);
		else eased_value = OW'(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			op_q     <= OP_UU;
			iter_q   <= '0;
			mode_y_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					op_q     <= OP_UU;
					iter_q   <= '0;
					mode_y_q <= 1'b0;
				end
				ST_MUL: op_q <= (op_q == OP_C) ? OP_DA : op_q + 4'd1;
				ST_CHECK: op_q <= OP_DA;
				ST_DIVSET: cnt_q <= '0;
				ST_DIV: cnt_q <= cnt_q + CW'(1);
				ST_UPD: begin
					iter_q <= iter_q + IW'(1);
					op_q   <= OP_UU;
				end
				ST_FINAL: begin
					mode_y_q <= 1'b1;
					op_q     <= OP_UU;
				end
				ST_OUT: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				t_q   <= time_frac;
				s_q   <= SW'($signed({1'b0, time_frac}));
				acc_q <= t_big ? D_ONE : '0;
			end
			ST_MUL: begin
				unique case (op_q)
					OP_UU:  uu_q  <= MW'(prod);
					OP_US:  us_q  <= MW'(prod);
					OP_SS:  ss_q  <= MW'(prod);
					OP_UUS, OP_USS: tmp_q <= MW'(prod);
					default: ;
				endcase
				acc_q <= acc_q + term;
			end
			ST_CHECK: begin
				e_q   <= e_now;
				acc_q <= '0;
			end
			ST_DIVSET: begin
				neg_q <= e_q[DW-1] ^ acc_q[DW-1];
				den_q <= acc_q[DW-1] ? DW'(-acc_q) : DW'(acc_q);
				num_q <= NW'(e_q[DW-1] ? DW'(-e_q) : DW'(e_q)) << FRAC_BITS;
				rem_q <= '0;
			end
			ST_DIV: begin
				if (!trial[DW]) begin
					rem_q <= trial[DW-1:0];
					num_q <= {num_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DW-2:0], num_q[NW-1]};
					num_q <= {num_q[NW-2:0], 1'b0};
				end
			end
			ST_UPD: begin
				if (s_new > (NW+2)'(S_LIM)) s_q <= S_LIM;
				else if (s_new < -(NW+2)'(S_LIM)) s_q <= -S_LIM;
				else s_q <= SW'(s_new);
				acc_q <= '0;
			end
			ST_FINAL: begin
				if (s_q < 0) s_q <= '0;
				else if (s_q > S_ONE) s_q <= S_ONE;
				acc_q <= '0;
			end
			default: ;
		endcase
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while still busy");
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= IW'(NEWTON_STEPS))
		else $error("newton step count overran");

endmodule

// ===== tb/sv/tb.sv =====
// testbench for cubic_bezier_timing_solver: directed table, then random time fractions
// results are checked against a fixed-point newton/bezier predictor; depends on cbts_pkg
`timescale 1ns / 1ps

module tb;
	import cbts_pkg::*;

	localparam int FB = 16;
	localparam longint ONE = 64'sd1 << FB;
	localparam logic [2:0] REG_NONE = 3'd5;

	typedef struct {
		logic [16:0] t;
		bit          has_exp;
		logic [18:0] exp_val;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [16:0] time_frac = '0;
	logic        done;
	logic signed [18:0] eased_value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [17:0] cfg_data = '0;

	logic [16:0] p1x, p2x;
	logic [17:0] p1y, p2y;
	logic [18:0] eased_q[$];
	int errors = 0;
	bit quiet = 1'b0;

	cubic_bezier_timing_solver dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .time_frac(time_frac),
		.done(done), .eased_value(eased_value), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// product scaled down, rounded half away from zero
	function automatic longint qmul(longint a, longint b);
		longint ma, mb, r;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		r = (ma * mb + (64'sd1 <<< (FB - 1))) >>> FB;
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint curve_at(longint c1, longint c2, longint s);
		longint u;
		u = ONE - s;
		return 3 * qmul(qmul(qmul(u, u), s), c1) + 3 * qmul(qmul(qmul(u, s), s), c2)
			+ qmul(qmul(s, s), s);
	endfunction

	function automatic longint slope_at(longint c1, longint c2, longint s);
		longint u;
		u = ONE - s;
		return 3 * qmul(qmul(u, u), c1) + 6 * qmul(qmul(u, s), c2 - c1)
			+ 3 * qmul(qmul(s, s), ONE - c2);
	endfunction

	function automatic logic [18:0] ease(logic [16:0] tf);
		longint t, s, e, d, y, c1x, c2x, c1y, c2y;
		t = tf;
		c1x = p1x;
		c2x = p2x;
		c1y = longint'(signed'(p1y));
		c2y = longint'(signed'(p2y));
		if (t == 0) y = 0;
		else if (t >= ONE) y = ONE;
		else begin
			s = t;
			for (int i = 0; i < 8; i++) begin
				e = curve_at(c1x, c2x, s) - t;
				if (e > -NEWTON_TOL && e < NEWTON_TOL) break;
				d = slope_at(c1x, c2x, s);
				if (d == 0) break;
				s -= (e * ONE) / d;
				if (s < -4 * ONE) s = -4 * ONE;
				if (s > 4 * ONE) s = 4 * ONE;
			end
			if (s < 0) s = 0;
			if (s > ONE) s = ONE;
			y = curve_at(c1y, c2y, s);
		end
		if (y < -(64'sd1 << 18)) y = -(64'sd1 << 18);
		if (y > (64'sd1 << 18) - 1) y = (64'sd1 << 18) - 1;
		return y[18:0];
	endfunction

	always @(posedge clk) begin
		if (done) begin
			if (eased_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %0d", eased_value);
			end else begin
				if (eased_value !== eased_q[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %0d got %0d",
							$signed(eased_q[0]), eased_value);
				end
				void'(eased_q.pop_front());
			end
		end
	end

	task automatic hold_off();
		if (!quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 15)) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [17:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CTRL1_X: p1x = val[16:0];
			REG_CTRL1_Y: p1y = val;
			REG_CTRL2_X: p2x = val[16:0];
			REG_CTRL2_Y: p2y = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_time(logic [16:0] tf, bit has_exp, logic [18:0] ev);
		hold_off();
		start <= 1'b1;
		time_frac <= tf;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		eased_q.push_back(has_exp ? ev : ease(tf));
		// the block stays busy through this edge
		@(posedge clk);
	endtask

	task automatic drain();
		int n;
		n = 0;
		while (eased_q.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic set_curve(logic [16:0] ax, logic [17:0] ay, logic [16:0] bx,
			logic [17:0] by);
		drain();
		write_reg(REG_CTRL1_X, {1'b0, ax});
		write_reg(REG_CTRL1_Y, ay);
		write_reg(REG_CTRL2_X, {1'b0, bx});
		write_reg(REG_CTRL2_Y, by);
	endtask

	stim_row_t dir_rows[] = '{
		'{17'd0, 1, 19'd0}, '{17'd65536, 1, 19'd65536}, '{17'h1ffff, 1, 19'd65536},
		'{17'd1, 0, 0}, '{17'd65535, 0, 0}, '{17'd32768, 0, 0}, '{17'd12345, 0, 0},
		'{17'd54321, 0, 0}, '{17'h15555, 1, 19'd65536}, '{17'h0aaaa, 0, 0}
	};

	initial begin
		p1x = 0; p1y = 0; p2x = 17'd65536; p2y = 18'd65536;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset curve first, then ease-style and the extremes
		foreach (dir_rows[i]) send_time(dir_rows[i].t, dir_rows[i].has_exp, dir_rows[i].exp_val);
		set_curve(17'd16384, 18'd6554, 17'd16384, 18'd65536);
		foreach (dir_rows[i]) send_time(dir_rows[i].t, 0, 0);
		set_curve(17'h1ffff, 18'h1ffff, 17'd0, 18'h20000);
		foreach (dir_rows[i]) send_time(dir_rows[i].t, 0, 0);
		set_curve(17'd65536, 18'h20000, 17'd65536, 18'h1ffff);
		foreach (dir_rows[i]) send_time(dir_rows[i].t, 0, 0);
		drain();
		write_reg(REG_NONE, 18'h3ffff);   // unknown index, ignored
		send_time(17'd30000, 0, 0);
		for (int ph = 0; ph < 13; ph++) begin
			if (ph == 12) quiet = 1'b1;
			if (ph % 4 == 3)
				set_curve(17'($urandom), 18'($urandom), 17'($urandom), 18'($urandom));
			else
				set_curve(17'($urandom_range(0, 65536)),
					18'($signed($urandom_range(0, 196608)) - 65536),
					17'($urandom_range(0, 65536)),
					18'($signed($urandom_range(0, 196608)) - 65536));
			for (int k = 0; k < 50; k++) begin
				case ($urandom_range(0, 9))
					0: send_time(17'($urandom), 0, 0);
					1: send_time(17'($urandom_range(0, 8)), 0, 0);
					2: send_time(17'($urandom_range(65528, 65536)), 0, 0);
					default: send_time(17'($urandom_range(1, 65535)), 0, 0);
				endcase
			end
		end
		drain();
		if (errors == 0 && eased_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
